### rtl/track_plane_residual_histogram_top_defines.svh
// ----------------------------------------------------------------------------
// Track plane residual histogram: assertion macros
// Immediate-implication and next-cycle checks on the clock and reset ports.
// ----------------------------------------------------------------------------
`ifndef TRACK_PLANE_RESIDUAL_HISTOGRAM_TOP_DEFINES_SVH
`define TRACK_PLANE_RESIDUAL_HISTOGRAM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TPRH_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tprh check failed");
`define TPRH_ASSERT_NXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tprh check failed");
`else
`define TPRH_ASSERT_IMP(lbl, pre, post)
`define TPRH_ASSERT_NXT(lbl, pre, post)
`endif
`endif

### rtl/tprh_pkg.sv
// ----------------------------------------------------------------------------
// Track plane residual histogram package
// Codes, widths and the request/result structs of the shared units.
// ----------------------------------------------------------------------------
package tprh_pkg;
   localparam int DVD_W = 66;
   localparam int QUO_W = 41;
   localparam int NUM_W = 34;
   localparam int OFS_W = 42;
   localparam int ERR_W = 44;

   localparam logic [1:0] ACT_HEADER = 2'd0;
   localparam logic [1:0] ACT_TRACK  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic [2:0] STS_FILLED     = 3'd0;
   localparam logic [2:0] STS_NO_HITS    = 3'd1;
   localparam logic [2:0] STS_NO_TRACKS  = 3'd2;
   localparam logic [2:0] STS_FEW_POINTS = 3'd3;
   localparam logic [2:0] STS_ZERO_DZ    = 3'd4;
   localparam logic [2:0] STS_READ       = 3'd5;

   localparam logic [2:0] REG_FILL_WEIGHT = 3'd0;
   localparam logic [2:0] REG_REFERENCE_Z = 3'd1;
   localparam logic [2:0] REG_Z_SHIFT     = 3'd2;
   localparam logic [2:0] REG_BIN_WIDTH   = 3'd3;
   localparam logic [2:0] REG_MIN_POINTS  = 3'd4;

   localparam logic [47:0]      SUM_MAX   = '1;
   localparam logic [QUO_W-1:0] OFS_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [31:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             sat;
      logic [QUO_W-1:0] quo;
   } div_res_type;

   typedef struct packed {
      logic        start;
      logic [63:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_res_type;
endpackage

### rtl/tprh_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// 66-bit dividend by 32-bit divisor, one quotient bit per cycle; keeps the
// low 41 quotient bits and flags any set bit above them.
// ----------------------------------------------------------------------------
module tprh_div
   import tprh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_res_type res
);
   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff;
   logic             done_ff;
   logic             sat_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [31:0]      dvs_ff;
   logic [31:0]      rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [32:0]      trial;
   logic             ge;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         dvd_ff <= req.dividend;
         dvs_ff <= req.divisor;
         rem_ff <= '0;
         quo_ff <= '0;
         sat_ff <= 1'b0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
         // a quotient bit above the kept range means saturation
         if (ge && (cnt_ff >= CNT_W'(QUO_W))) begin
            sat_ff <= 1'b1;
         end
      end
   end

   assign res.done = done_ff;
   assign res.sat  = sat_ff;
   assign res.quo  = quo_ff;
endmodule

### rtl/tprh_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tprh_sqrt
   import tprh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_res_type res
);
   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] v_ff;
   logic [63:0] r_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;
   logic        ge;

   assign trial = r_ff + bit_ff;
   assign ge    = v_ff >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         v_ff   <= req.value;
         r_ff   <= '0;
         bit_ff <= {2'b01, 62'b0};
      end else if (busy_ff) begin
         if (ge) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign res.done = done_ff;
   assign res.root = r_ff[31:0];
endmodule

### rtl/track_plane_residual_histogram_top.sv
// ----------------------------------------------------------------------------
// Track plane residual histogram
// Keeps the best track of each event, projects it and the true line to the
// reference plane and fills the transverse distance into a histogram.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one item per event header, track or bin read; an item is
//  taken when req_valid is high and req_stall low. rsp_* carries results
//  with the same valid/stall rule. csr_* writes the five registers; csr_ready
//  is always high; registers must change only while the block is idle, which
//  the block itself does not enforce. Headers, ignored items and tracks that
//  leave the event open are handled in the idle state; a read passes S_RRD
//  and S_RDO before its result. The last track of an event starts the close
//  sequence: four offsets, each two 32x32 multiplier passes and a restoring
//  divide, then two squares, a square root, a bin divide and a read-modify-
//  write of the bin memory; a saturated error skips squares and root, a zero
//  bin width skips the bin divide. The block takes no item while it works or
//  while a result waits; a stalled result simply holds, and the block waits
//  with it. Reset clears the registers to their defaults and marks every bin
//  empty through per-bin valid flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "track_plane_residual_histogram_top_defines.svh"

module track_plane_residual_histogram_top
   import tprh_pkg::*;
#(
   parameter int N_BINS     = 100,
   parameter int MAX_TRACKS = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic [31:0]        req_chi2,
   input  logic [7:0]         req_n_points,
   input  logic [15:0]        req_hit_channels,
   input  logic [7:0]         req_track_count,
   input  logic [6:0]         req_bin_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_distance,
   output logic [6:0]         rsp_bin_hit,
   output logic [2:0]         rsp_status,
   output logic [47:0]        rsp_bin_sum,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int IW = $clog2(N_BINS + 1);

   typedef enum logic [16:0] {
      S_IDLE = 17'h00001,
      S_MLO  = 17'h00002,
      S_MHI  = 17'h00004,
      S_DST  = 17'h00008,
      S_DWT  = 17'h00010,
      S_COMB = 17'h00020,
      S_CHK  = 17'h00040,
      S_SQX  = 17'h00080,
      S_SQY  = 17'h00100,
      S_SQS  = 17'h00200,
      S_SQW  = 17'h00400,
      S_BIN  = 17'h00800,
      S_BWT  = 17'h01000,
      S_HRD  = 17'h02000,
      S_HWR  = 17'h04000,
      S_RRD  = 17'h08000,
      S_RDO  = 17'h10000
   } state_type;

   localparam logic signed [ERR_W-1:0] ERR_LIM = 44'sd2147483648;

   state_type          state_ff;
   logic [31:0]        fill_weight_ff;
   logic signed [31:0] reference_z_ff;
   logic signed [31:0] z_shift_ff;
   logic [31:0]        bin_width_ff;
   logic [7:0]         min_points_ff;

   logic signed [31:0] truth_ff [6];
   logic signed [31:0] best_ff [6];
   logic [31:0]        best_chi2_ff;
   logic [7:0]         first_pts_ff;
   logic [7:0]         tracks_left_ff;
   logic               open_ff;
   logic               have_ff;

   logic [1:0]              job_ff;
   logic [63:0]             mul_ff;
   logic [63:0]             lo_ff;
   logic signed [OFS_W-1:0] off_ff [4];
   logic signed [ERR_W-1:0] ex_ff;
   logic signed [ERR_W-1:0] ey_ff;
   logic [31:0]             dist_ff;
   logic [IW-1:0]           bin_ff;
   logic                    rd_ok_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_distance_ff;
   logic [6:0]  rsp_bin_hit_ff;
   logic [2:0]  rsp_status_ff;
   logic [47:0] rsp_bin_sum_ff;

   logic [47:0]   hist_mem [0:N_BINS];
   logic [N_BINS:0] hvalid_ff;
   logic [47:0]   rd_data_ff;
   logic          rd_vld_ff;
   logic          hwe;

   logic                    accept;
   logic signed [NUM_W-1:0] numt;
   logic signed [NUM_W-1:0] numb;
   logic signed [NUM_W-1:0] jnum;
   logic signed [31:0]      jd;
   logic signed [31:0]      jdz;
   logic                    jneg;
   logic [NUM_W-1:0]        ja;
   logic [31:0]             jb;
   logic [31:0]             jc;
   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic [DVD_W-1:0]        prod;
   logic [QUO_W-1:0]        omag;
   logic signed [OFS_W-1:0] ofs;
   logic [31:0]             ux;
   logic [31:0]             uy;
   logic                    err_sat;
   logic [IW-1:0]           bin_q;
   logic [47:0]             hcur;
   logic [48:0]             hsum_full;
   logic [47:0]             hsum;
   logic [31:0]             bin32;

   logic [7:0]  pts_new;
   logic        take;
   logic signed [31:0] dz_best_new;
   logic [7:0]  tl_new;
   logic [7:0]  cnt_clamp;

   div_req_type  div_req;
   div_res_type  div_res;
   sqrt_req_type sqrt_req;
   sqrt_res_type sqrt_res;

   tprh_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   tprh_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .res   (sqrt_res)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;

   // projection operands of the current offset job
   always_comb begin
      numt = NUM_W'(reference_z_ff) - NUM_W'(truth_ff[2]);
      numb = NUM_W'(reference_z_ff) - NUM_W'(best_ff[2]) - NUM_W'(z_shift_ff);
      if (job_ff[1]) begin
         jnum = numb;
         jd   = job_ff[0] ? best_ff[4] : best_ff[3];
         jdz  = best_ff[5];
      end else begin
         jnum = numt;
         jd   = job_ff[0] ? truth_ff[4] : truth_ff[3];
         jdz  = truth_ff[5];
      end
      jneg = jnum[NUM_W-1] ^ jd[31] ^ jdz[31];
      ja   = jnum[NUM_W-1] ? NUM_W'(-jnum) : NUM_W'(jnum);
      jb   = jd[31] ? 32'(-jd) : 32'(jd);
      jc   = jdz[31] ? 32'(-jdz) : 32'(jdz);
      ux   = ex_ff[ERR_W-1] ? 32'(-ex_ff) : 32'(ex_ff);
      uy   = ey_ff[ERR_W-1] ? 32'(-ey_ff) : 32'(ey_ff);
      prod = {2'b00, lo_ff} + {mul_ff[NUM_W-1:0], 32'b0};
      omag = (div_res.sat || (div_res.quo > OFS_LIMIT)) ? OFS_LIMIT : div_res.quo;
      ofs  = jneg ? -$signed(OFS_W'(omag)) : $signed(OFS_W'(omag));
      err_sat = (ex_ff >= ERR_LIM) || (ex_ff <= -ERR_LIM) ||
                (ey_ff >= ERR_LIM) || (ey_ff <= -ERR_LIM);
      bin_q = (div_res.quo > QUO_W'(N_BINS)) ? IW'(N_BINS) : IW'(div_res.quo);
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MLO: begin
            mul_a = ja[31:0];
            mul_b = jb;
         end
         S_MHI: begin
            mul_a = 32'(ja[NUM_W-1:32]);
            mul_b = jb;
         end
         S_SQX: begin
            mul_a = ux;
            mul_b = ux;
         end
         S_SQY: begin
            mul_a = uy;
            mul_b = uy;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      div_req.start    = (state_ff == S_DST) || ((state_ff == S_BIN) && (bin_width_ff != '0));
      div_req.dividend = (state_ff == S_DST) ? prod : DVD_W'(dist_ff);
      div_req.divisor  = (state_ff == S_DST) ? jc : bin_width_ff;
      sqrt_req.start   = (state_ff == S_SQS);
      sqrt_req.value   = lo_ff + mul_ff;
   end

   always_comb begin
      pts_new     = have_ff ? first_pts_ff : req_n_points;
      take        = !have_ff || (req_chi2 < best_chi2_ff);
      dz_best_new = take ? req_dir_z : best_ff[5];
      tl_new      = tracks_left_ff - 8'(tracks_left_ff != '0);
      cnt_clamp   = (req_track_count > 8'(MAX_TRACKS)) ? 8'(MAX_TRACKS) : req_track_count;
      hcur        = rd_vld_ff ? rd_data_ff : '0;
      hsum_full   = {1'b0, hcur} + 49'(fill_weight_ff);
      hsum        = hsum_full[48] ? SUM_MAX : hsum_full[47:0];
      hwe         = (state_ff == S_HWR);
      bin32       = 32'(bin_ff);
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // bin memory, read every cycle at bin_ff
   always_ff @(posedge clock) begin
      if (hwe) begin
         hist_mem[bin_ff] <= hsum;
      end
      rd_data_ff <= hist_mem[bin_ff];
      rd_vld_ff  <= hvalid_ff[bin_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_ff <= '0;
      end else if (hwe) begin
         hvalid_ff[bin_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_weight_ff <= 32'd65536;
         reference_z_ff <= -32'sd5568000;
         z_shift_ff     <= 32'sd6643200;
         bin_width_ff   <= 32'd5120;
         min_points_ff  <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FILL_WEIGHT: fill_weight_ff <= csr_data;
            REG_REFERENCE_Z: reference_z_ff <= $signed(csr_data);
            REG_Z_SHIFT:     z_shift_ff     <= $signed(csr_data);
            REG_BIN_WIDTH:   bin_width_ff   <= csr_data;
            REG_MIN_POINTS:  min_points_ff  <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         best_chi2_ff   <= '1;
         first_pts_ff   <= '0;
         tracks_left_ff <= '0;
         open_ff        <= 1'b0;
         have_ff        <= 1'b0;
         job_ff         <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_distance_ff <= '0;
                  rsp_bin_hit_ff  <= '0;
                  rsp_bin_sum_ff  <= '0;
                  case (req_action)
                     ACT_HEADER: begin
                        truth_ff[0]  <= req_pos_x;
                        truth_ff[1]  <= req_pos_y;
                        truth_ff[2]  <= req_pos_z;
                        truth_ff[3]  <= req_dir_x;
                        truth_ff[4]  <= req_dir_y;
                        truth_ff[5]  <= req_dir_z;
                        open_ff      <= 1'b0;
                        have_ff      <= 1'b0;
                        best_chi2_ff <= '1;
                        if (req_hit_channels == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= STS_NO_HITS;
                        end else if (req_track_count == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= STS_NO_TRACKS;
                        end else begin
                           tracks_left_ff <= cnt_clamp;
                           open_ff        <= 1'b1;
                        end
                     end
                     ACT_TRACK: begin
                        if (open_ff) begin
                           first_pts_ff   <= pts_new;
                           have_ff        <= 1'b1;
                           tracks_left_ff <= tl_new;
                           if (take) begin
                              best_chi2_ff <= req_chi2;
                              best_ff[0]   <= req_pos_x;
                              best_ff[1]   <= req_pos_y;
                              best_ff[2]   <= req_pos_z;
                              best_ff[3]   <= req_dir_x;
                              best_ff[4]   <= req_dir_y;
                              best_ff[5]   <= req_dir_z;
                           end
                           if (tl_new == '0) begin
                              open_ff <= 1'b0;
                              if (pts_new < min_points_ff) begin
                                 rsp_valid_ff  <= 1'b1;
                                 rsp_status_ff <= STS_FEW_POINTS;
                              end else if ((truth_ff[5] == '0) || (dz_best_new == '0)) begin
                                 rsp_valid_ff  <= 1'b1;
                                 rsp_status_ff <= STS_ZERO_DZ;
                              end else begin
                                 job_ff   <= '0;
                                 state_ff <= S_MLO;
                              end
                           end
                        end
                     end
                     ACT_READ: begin
                        rd_ok_ff <= (32'(req_bin_index) <= N_BINS);
                        if (32'(req_bin_index) <= N_BINS) begin
                           bin_ff <= IW'(req_bin_index);
                        end
                        state_ff <= S_RRD;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_MLO: state_ff <= S_MHI;
            S_MHI: begin
               lo_ff    <= mul_ff;
               state_ff <= S_DST;
            end
            S_DST: state_ff <= S_DWT;
            S_DWT: begin
               if (div_res.done) begin
                  off_ff[job_ff] <= ofs;
                  if (job_ff == 2'd3) begin
                     state_ff <= S_COMB;
                  end else begin
                     job_ff   <= job_ff + 2'd1;
                     state_ff <= S_MLO;
                  end
               end
            end
            S_COMB: begin
               ex_ff <= (ERR_W'(truth_ff[0]) + ERR_W'(off_ff[0])) -
                        (ERR_W'(best_ff[0]) + ERR_W'(off_ff[2]));
               ey_ff <= (ERR_W'(truth_ff[1]) + ERR_W'(off_ff[1])) -
                        (ERR_W'(best_ff[1]) + ERR_W'(off_ff[3]));
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (err_sat) begin
                  dist_ff  <= '1;
                  state_ff <= S_BIN;
               end else begin
                  state_ff <= S_SQX;
               end
            end
            S_SQX: state_ff <= S_SQY;
            S_SQY: begin
               lo_ff    <= mul_ff;
               state_ff <= S_SQS;
            end
            S_SQS: state_ff <= S_SQW;
            S_SQW: begin
               if (sqrt_res.done) begin
                  dist_ff  <= sqrt_res.root;
                  state_ff <= S_BIN;
               end
            end
            S_BIN: begin
               if (bin_width_ff == '0) begin
                  bin_ff   <= IW'(N_BINS);
                  state_ff <= S_HRD;
               end else begin
                  state_ff <= S_BWT;
               end
            end
            S_BWT: begin
               if (div_res.done) begin
                  bin_ff   <= bin_q;
                  state_ff <= S_HRD;
               end
            end
            S_HRD: state_ff <= S_HWR;
            S_HWR: begin
               rsp_valid_ff    <= 1'b1;
               rsp_status_ff   <= STS_FILLED;
               rsp_distance_ff <= dist_ff;
               rsp_bin_hit_ff  <= bin32[6:0];
               state_ff        <= S_IDLE;
            end
            S_RRD: state_ff <= S_RDO;
            S_RDO: begin
               rsp_valid_ff   <= 1'b1;
               rsp_status_ff  <= STS_READ;
               rsp_bin_sum_ff <= rd_ok_ff ? hcur : '0;
               state_ff       <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_bin_hit  = rsp_bin_hit_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_bin_sum  = rsp_bin_sum_ff;

   `TPRH_ASSERT_IMP(a_div_done_wait, div_res.done, (state_ff == S_DWT) || (state_ff == S_BWT))
   `TPRH_ASSERT_IMP(a_sqrt_done_wait, sqrt_res.done, state_ff == S_SQW)
   `TPRH_ASSERT_NXT(a_fill_result, state_ff == S_HWR, rsp_valid_ff && (rsp_status_ff == STS_FILLED))
   `TPRH_ASSERT_IMP(a_busy_stalls, state_ff != S_IDLE, req_stall)
endmodule
